// File: rtl/bft_pkg.sv
// shared types and constants for the bidirectional flow table
// no dependencies
`default_nettype none

package bft_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic [7:0]  PROTO_TCP   = 8'd6;
  localparam logic [7:0]  PROTO_UDP   = 8'd17;
  localparam logic [15:0] LIMIT_RESET = 16'd1000;

  typedef enum logic [1:0] {
    ST_OTHER = 2'd0,
    ST_HIT   = 2'd1,
    ST_ADDED = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [7:0]  proto_number;
    logic [15:0] src_l4;
    logic [15:0] dst_l4;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [9:0]  flow_slot;
    logic [31:0] flow_packets;
    logic [31:0] total_packets;
    logic        limit_reached;
    logic [10:0] tcp_flows;
    logic [10:0] udp_flows;
  } out_t;

  // one stored flow
  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_l4;
    logic [15:0] dst_l4;
    logic [31:0] packets;
    logic        is_tcp;
  } entry_t;

endpackage

`default_nettype wire

// File: rtl/bidirectional_flow_table.sv
// Bidirectional flow table: linear search over one flow memory; uses bft_pkg.
// Steps: a non TCP/UDP word goes from S_IDLE straight to S_FIN; a TCP/UDP word is
// compared in S_SCAN from entry 0 until a hit or the last stored entry, a miss then goes
// to S_INSERT (straight there if the table is empty), and S_FIN registers the result.
// The next word is accepted only back in S_IDLE, after the result issues; a result left waiting stalls that.
// Reset: counters cleared, limit 1000, table contents undefined (no clearing pass).
`default_nettype none

module bidirectional_flow_table (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  bft_pkg::in_t      in_data_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output bft_pkg::out_t     out_data_o,
  input  wire               cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire [15:0]        cfg_data_i
);
  import bft_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_INSERT,
    S_FIN
  } state_e;

  state_e            state_q;
  in_t               key_q;
  logic [IDX_W-1:0]  cmp_q;
  logic [CNT_W-1:0]  used_q, tcp_q, udp_q;
  logic [31:0]       seen_q;
  logic [15:0]       limit_q;
  status_e           res_status_q;
  logic [IDX_W-1:0]  res_idx_q;
  logic [31:0]       res_pkts_q;
  logic              out_valid_q;
  out_t              out_q;

  entry_t            table_mem [TABLE_DEPTH];
  entry_t            rdata_q;
  entry_t            wdata;
  logic [IDX_W-1:0]  rd_addr, wr_addr;
  logic              we;

  logic              is_flow_proto, fwd, rev, match, last, full, out_free;
  logic [31:0]       hit_pkts;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;

  assign is_flow_proto = (in_data_i.proto_number == PROTO_TCP) ||
                         (in_data_i.proto_number == PROTO_UDP);

  // match in either direction, protocol ignored
  assign fwd = (rdata_q.src_addr == key_q.src_addr) && (rdata_q.dst_addr == key_q.dst_addr) &&
               (rdata_q.src_l4 == key_q.src_l4) && (rdata_q.dst_l4 == key_q.dst_l4);
  assign rev = (rdata_q.src_addr == key_q.dst_addr) && (rdata_q.dst_addr == key_q.src_addr) &&
               (rdata_q.src_l4 == key_q.dst_l4) && (rdata_q.dst_l4 == key_q.src_l4);
  assign match    = fwd || rev;
  assign last     = ({1'b0, cmp_q} + CNT_W'(1)) == used_q;
  assign full     = (used_q == CNT_W'(TABLE_DEPTH));
  assign hit_pkts = (rdata_q.packets != '1) ? rdata_q.packets + 32'd1 : rdata_q.packets;

  always_comb begin
    rd_addr = '0;
    if (state_q == S_SCAN) begin
      rd_addr = cmp_q + IDX_W'(1);
    end
  end

  always_comb begin
    we      = 1'b0;
    wr_addr = cmp_q;
    wdata   = rdata_q;
    if (state_q == S_SCAN && match) begin
      we            = 1'b1;
      wdata.packets = hit_pkts;
    end else if (state_q == S_INSERT && !full) begin
      we             = 1'b1;
      wr_addr        = used_q[IDX_W-1:0];
      wdata.src_addr = key_q.src_addr;
      wdata.dst_addr = key_q.dst_addr;
      wdata.src_l4   = key_q.src_l4;
      wdata.dst_l4   = key_q.dst_l4;
      wdata.packets  = 32'd1;
      wdata.is_tcp   = (key_q.proto_number == PROTO_TCP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      table_mem[wr_addr] <= wdata;
    end
    rdata_q <= table_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      key_q        <= '0;
      cmp_q        <= '0;
      used_q       <= '0;
      tcp_q        <= '0;
      udp_q        <= '0;
      seen_q       <= '0;
      limit_q      <= LIMIT_RESET;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
      res_status_q <= ST_OTHER;
      res_idx_q    <= '0;
      res_pkts_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
      // in S_FIN the result register is loaded below instead
      if (out_valid_q && out_ready_i && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            key_q      <= in_data_i;
            cmp_q      <= '0;
            res_idx_q  <= '0;
            res_pkts_q <= '0;
            if (seen_q != '1) begin
              seen_q <= seen_q + 32'd1;
            end
            if (!is_flow_proto) begin
              res_status_q <= ST_OTHER;
              state_q      <= S_FIN;
            end else if (used_q == '0) begin
              state_q <= S_INSERT;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          cmp_q <= cmp_q + IDX_W'(1);
          if (match) begin
            res_status_q <= ST_HIT;
            res_idx_q    <= cmp_q;
            res_pkts_q   <= hit_pkts;
            state_q      <= S_FIN;
          end else if (last) begin
            state_q <= S_INSERT;
          end
        end
        S_INSERT: begin
          if (full) begin
            res_status_q <= ST_FULL;
          end else begin
            res_status_q <= ST_ADDED;
            res_idx_q    <= used_q[IDX_W-1:0];
            res_pkts_q   <= 32'd1;
            used_q       <= used_q + CNT_W'(1);
            if (key_q.proto_number == PROTO_TCP) begin
              tcp_q <= tcp_q + CNT_W'(1);
            end else begin
              udp_q <= udp_q + CNT_W'(1);
            end
          end
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_q              <= 1'b1;
            out_q.status             <= res_status_q;
            out_q.flow_slot          <= 10'(res_idx_q);
            out_q.flow_packets       <= res_pkts_q;
            out_q.total_packets      <= seen_q;
            out_q.limit_reached      <= (seen_q >= {16'd0, limit_q});
            out_q.tcp_flows          <= 11'(tcp_q);
            out_q.udp_flows          <= 11'(udp_q);
            state_q                  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
